FILE: src/ffza_pkg.sv
// Package: shared constants, register codes and state type of the zone allocator.
package ffza_pkg;

  // Storage dimensions
  localparam int MAX_ZONES    = 64;
  localparam int POINTER_BITS = 17;

  // Field widths of the channels and registers
  localparam int MODE_BITS      = 1;
  localparam int ZSEL_BITS      = 6;
  localparam int AMOUNT_BITS    = 17;
  localparam int TAG_BITS       = 6;
  localparam int ADDR_BITS      = 22;
  localparam int CAP_BITS       = 17;
  localparam int ZONES_BITS     = 7;
  localparam int CFG_DATA_BITS  = 17;
  localparam int CFG_INDEX_BITS = 1;

  // Derived widths
  localparam int ZONE_BITS = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
  localparam int CNT_BITS  = $clog2(MAX_ZONES + 1);
  localparam int CMP_BITS  = ((POINTER_BITS > CAP_BITS) ? POINTER_BITS : CAP_BITS) + 1;
  localparam int PROD_BITS = ZONE_BITS + CMP_BITS + 1;
  localparam int SUM_BITS  = (PROD_BITS > ADDR_BITS) ? PROD_BITS : ADDR_BITS;

  // Capacity ceiling and reset values
  localparam logic [CAP_BITS-1:0]   CAP_LIMIT   = CAP_BITS'(65536);
  localparam logic [CAP_BITS-1:0]   CAP_RESET   = CAP_BITS'(65536);
  localparam logic [ZONES_BITS-1:0] ZONES_RESET = ZONES_BITS'(64);

  // Register indexes of the configuration port
  localparam logic [CFG_INDEX_BITS-1:0] REG_ZONE_CAPACITY = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ZONES_IN_USE  = 1'b1;

  // Request modes
  localparam logic [MODE_BITS-1:0] MODE_LOAD  = 1'b0;
  localparam logic [MODE_BITS-1:0] MODE_ALLOC = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

FILE: src/ffza_req_if.sv
// Interface: request channel (load or allocate items) with valid/ready handshake.
interface ffza_req_if;
  import ffza_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [MODE_BITS-1:0]   mode;
  logic [ZSEL_BITS-1:0]   zone_select;
  logic [AMOUNT_BITS-1:0] amount;
  logic [TAG_BITS-1:0]    request_tag;

  modport source (output valid, mode, zone_select, amount, request_tag, input ready);
  modport sink   (input valid, mode, zone_select, amount, request_tag, output ready);
endinterface

FILE: src/ffza_rsp_if.sv
// Interface: result channel (found flag, block address, tag) with valid/ready handshake.
interface ffza_rsp_if;
  import ffza_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 found;
  logic [ADDR_BITS-1:0] block_address;
  logic [TAG_BITS-1:0]  tag;

  modport source (output valid, found, block_address, tag, input ready);
  modport sink   (input valid, found, block_address, tag, output ready);
endinterface

FILE: src/first_fit_zone_allocator.sv
// Top level: first-fit zone allocator over a RAM of per-zone write pointers.
//
//   channel  role    handshake      payload
//   req      sink    valid/ready    mode, zone_select, amount, request_tag
//   rsp      source  valid/ready    found, block_address, tag
//   cfg      sink    cfg_we only    cfg_index, cfg_data
//
// A load writes the pointer at the transfer; its result is registered when the
// output register is free. An allocate reads one zone pointer per cycle from
// the pointer RAM until a zone fits or the zones in use end. Reset sets the
// control registers and clears a valid bit per zone; an unwritten zone reads
// as pointer zero, so no clearing pass is needed. The result register lets the
// next request transfer while a result is stalled on rsp.ready.
module first_fit_zone_allocator (
  input  logic                              clk,
  input  logic                              rst,
  ffza_req_if.sink                          req,
  ffza_rsp_if.source                        rsp,
  input  logic                              cfg_we,
  input  logic [ffza_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [ffza_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import ffza_pkg::*;

  // Configuration registers
  logic [CAP_BITS-1:0]   zone_capacity;
  logic [ZONES_BITS-1:0] zones_in_use;

  // Sequencer and request context
  state_t                 state, state_next;
  logic [CNT_BITS-1:0]    scan_zone;
  logic [CNT_BITS-1:0]    scan_limit;
  logic [AMOUNT_BITS-1:0] req_amount;
  logic [TAG_BITS-1:0]    req_tag;
  logic                   req_alloc;
  logic                   res_found;
  logic [ZONE_BITS-1:0]   res_zone;
  logic [POINTER_BITS-1:0] res_ptr;
  logic [MAX_ZONES-1:0]   zone_valid;

  // Output register
  logic                 out_valid;
  logic                 out_found;
  logic [ADDR_BITS-1:0] out_address;
  logic [TAG_BITS-1:0]  out_tag;

  // RAM ports
  logic                    ram_we;
  logic [ZONE_BITS-1:0]    ram_waddr;
  logic [POINTER_BITS-1:0] ram_wdata;
  logic [ZONE_BITS-1:0]    ram_raddr;
  logic [POINTER_BITS-1:0] ram_rdata;

  // Datapath signals
  logic [CMP_BITS-1:0]  cap_ext;
  logic [CMP_BITS-1:0]  load_ext;
  logic [CMP_BITS-1:0]  load_sat;
  logic [CMP_BITS-1:0]  need_ext;
  logic [CMP_BITS-1:0]  wp_ext;
  logic [CMP_BITS-1:0]  free_ext;
  logic [CMP_BITS-1:0]  advanced;
  logic                 zone_fits;
  logic                 scan_last;
  logic [CNT_BITS-1:0]  limit_calc;
  logic                 req_xfer;
  logic                 req_is_alloc;
  logic                 load_in_range;
  logic                 out_load;
  logic [SUM_BITS-1:0]  addr_sum;

  ffza_ram #(
    .WIDTH (POINTER_BITS),
    .DEPTH (MAX_ZONES)
  ) u_ptr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Capacity clamp, load saturation and search limit
  always_comb begin
    if (zone_capacity > CAP_LIMIT) begin
      cap_ext = CMP_BITS'(CAP_LIMIT);
    end else begin
      cap_ext = CMP_BITS'(zone_capacity);
    end
    load_ext = CMP_BITS'(req.amount);
    load_sat = (load_ext > cap_ext) ? cap_ext : load_ext;
    if (int'(zones_in_use) > MAX_ZONES) begin
      limit_calc = CNT_BITS'(MAX_ZONES);
    end else begin
      limit_calc = CNT_BITS'(zones_in_use);
    end
    load_in_range = int'(req.zone_select) < MAX_ZONES;
    req_is_alloc  = (req.mode == MODE_ALLOC);
  end

  // Fit test on the pointer returned by the RAM
  always_comb begin
    wp_ext    = zone_valid[scan_zone[ZONE_BITS-1:0]] ? CMP_BITS'(ram_rdata) : '0;
    need_ext  = CMP_BITS'(req_amount);
    free_ext  = cap_ext - wp_ext;
    zone_fits = (wp_ext <= cap_ext) && (free_ext >= need_ext);
    advanced  = wp_ext + need_ext;
    scan_last = (scan_zone + 1'b1) == scan_limit;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          if (req_is_alloc && (limit_calc != '0)) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (zone_fits || scan_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || rsp.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    req.ready = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = ZONE_BITS'(req.zone_select);
    ram_wdata = load_sat[POINTER_BITS-1:0];
    ram_raddr = '0;
    out_load  = 1'b0;
    case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        ram_we    = req.valid && !req_is_alloc && load_in_range;
      end
      ST_SCAN: begin
        ram_raddr = ZONE_BITS'(scan_zone + 1'b1);
        ram_we    = zone_fits;
        ram_waddr = scan_zone[ZONE_BITS-1:0];
        ram_wdata = advanced[POINTER_BITS-1:0];
      end
      ST_DONE: begin
        out_load = !out_valid || rsp.ready;
      end
      default: begin
        req.ready = 1'b0;
      end
    endcase
  end

  assign req_xfer = req.valid && req.ready;

  // State and valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      zone_valid <= '0;
    end else begin
      state <= state_next;
      if (ram_we) begin
        zone_valid[ram_waddr] <= 1'b1;
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      zone_capacity <= CAP_RESET;
      zones_in_use  <= ZONES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ZONE_CAPACITY: zone_capacity <= cfg_data[CAP_BITS-1:0];
        REG_ZONES_IN_USE:  zones_in_use  <= cfg_data[ZONES_BITS-1:0];
        default:           zone_capacity <= zone_capacity;
      endcase
    end
  end

  // Request context and scan progress
  always_ff @(posedge clk) begin
    if (req_xfer) begin
      req_amount <= req.amount;
      req_tag    <= req.request_tag;
      req_alloc  <= req_is_alloc;
      scan_zone  <= '0;
      scan_limit <= limit_calc;
      res_found  <= !req_is_alloc;
      res_zone   <= '0;
      res_ptr    <= '0;
    end else if (state == ST_SCAN) begin
      if (zone_fits) begin
        res_found <= 1'b1;
        res_zone  <= scan_zone[ZONE_BITS-1:0];
        res_ptr   <= wp_ext[POINTER_BITS-1:0];
      end else begin
        scan_zone <= scan_zone + 1'b1;
      end
    end
  end

  // Block address of the hit zone
  assign addr_sum = SUM_BITS'(res_zone) * SUM_BITS'(cap_ext) + SUM_BITS'(res_ptr);

  // Output register: hold until transfer, load when free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found   <= res_found;
      out_tag     <= req_tag;
      out_address <= (res_found && req_alloc) ? addr_sum[ADDR_BITS-1:0] : '0;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.found         = out_found;
  assign rsp.block_address = out_address;
  assign rsp.tag           = out_tag;

endmodule

FILE: src/ffza_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ffza_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule
